[sv/lcdc_pkg.sv]
package lcdc_pkg;

	localparam int TEXT_CELLS_DEF = 16;
	localparam int FIFO_DEPTH_DEF = 2;

	localparam logic [1:0] ACC_INSTR  = 2'd0;
	localparam logic [1:0] ACC_STATUS = 2'd1;
	localparam logic [1:0] ACC_WRITE  = 2'd2;
	localparam logic [1:0] ACC_READ   = 2'd3;

	localparam logic [7:0] BLANK_CHAR = 8'h20;

	typedef enum logic [3:0] {
		OP_NOP       = 4'd0,
		OP_SET_ADDR  = 4'd1,
		OP_FUNC      = 4'd2,
		OP_SHIFT_INC = 4'd3,
		OP_SHIFT_DEC = 4'd4,
		OP_DISP      = 4'd5,
		OP_ENTRY     = 4'd6,
		OP_HOME      = 4'd7,
		OP_CLEAR     = 4'd8,
		OP_STATUS    = 4'd9,
		OP_WRITE     = 4'd10,
		OP_READ      = 4'd11
	} lcdc_op_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_in;
	} lcdc_req_t;

	typedef struct packed {
		logic [7:0] rd_byte;
		logic [6:0] address_now;
		logic       show_on;
		logic       cursor_on;
		logic       blink_on;
		logic       step_up;
		logic       wide_bus;
		logic       two_rows;
	} lcdc_rsp_t;

	typedef struct packed {
		lcdc_op_t   op;
		logic [7:0] arg;
	} lcdc_entry_t;

endpackage

[sv/lcdc_front.sv]
module lcdc_front import lcdc_pkg::*; (
	input  logic        start,
	input  lcdc_req_t   req,
	input  logic        full,
	output logic        busy,
	output logic        push,
	output lcdc_entry_t entry
);

	lcdc_op_t instr_op;

	always_comb begin
		unique case (req.data_in) inside
			8'b1???????: instr_op = OP_SET_ADDR;
			8'b01??????: instr_op = OP_NOP;
			8'b001?????: instr_op = OP_FUNC;
			8'b000100??: instr_op = OP_SHIFT_DEC;
			8'b000101??: instr_op = OP_SHIFT_INC;
			8'b00011???: instr_op = OP_NOP;
			8'b00001???: instr_op = OP_DISP;
			8'b000001??: instr_op = OP_ENTRY;
			8'b0000001?: instr_op = OP_HOME;
			8'b00000001: instr_op = OP_CLEAR;
			default:     instr_op = OP_NOP;
		endcase
	end

	always_comb begin
		unique case (req.cmd)
			ACC_INSTR:  entry.op = instr_op;
			ACC_STATUS: entry.op = OP_STATUS;
			ACC_WRITE:  entry.op = OP_WRITE;
			default:    entry.op = OP_READ;
		endcase
		entry.arg = req.data_in;
	end

	assign busy = full;
	assign push = start && !full;

endmodule

[sv/lcdc_fifo.sv]
module lcdc_fifo import lcdc_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  lcdc_entry_t wr_entry,
	input  logic        pop,
	output logic        full,
	output logic        empty,
	output lcdc_entry_t rd_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lcdc_entry_t       slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/lcdc_back.sv]
module lcdc_back import lcdc_pkg::*; #(
	parameter int TEXT_CELLS = TEXT_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        avail,
	input  lcdc_entry_t entry,
	output logic        pop,
	output logic        done,
	output lcdc_rsp_t   rsp
);

	localparam int IW = (TEXT_CELLS > 1) ? $clog2(TEXT_CELLS) : 1;

	logic [7:0]            mem [TEXT_CELLS];
	logic [TEXT_CELLS-1:0] valid_q;
	logic                  fill_q;

	logic [6:0] addr_q;
	logic       disp_q, cur_q, blink_q, inc_q, eight_q, two_q;

	logic [6:0] addr_d;
	logic       disp_d, cur_d, blink_d, inc_d, eight_d, two_d;
	logic       in_range;
	logic [IW-1:0] idx;
	logic       mem_we, mem_re, clr;

	logic       done_s2;
	logic       rd_s2;
	logic       hit_s2;
	logic       blank_s2;
	logic [7:0] mem_s2;
	logic [7:0] data_s2;
	lcdc_rsp_t  flags_s2;

	assign pop      = avail;
	assign in_range = (addr_q < 7'(TEXT_CELLS));
	assign idx      = addr_q[IW-1:0];
	assign mem_we   = avail && (entry.op == OP_WRITE) && in_range;
	assign mem_re   = avail && (entry.op == OP_READ) && in_range;
	assign clr      = avail && (entry.op == OP_CLEAR);

	always_comb begin
		addr_d  = addr_q;
		disp_d  = disp_q;
		cur_d   = cur_q;
		blink_d = blink_q;
		inc_d   = inc_q;
		eight_d = eight_q;
		two_d   = two_q;
		unique case (entry.op) inside
			OP_SET_ADDR:  addr_d = entry.arg[6:0];
			OP_FUNC: begin
				eight_d = entry.arg[4];
				two_d   = entry.arg[3];
			end
			OP_SHIFT_INC: addr_d = addr_q + 7'd1;
			OP_SHIFT_DEC: addr_d = addr_q - 7'd1;
			OP_DISP: begin
				disp_d  = entry.arg[2];
				cur_d   = entry.arg[1];
				blink_d = entry.arg[0];
			end
			OP_ENTRY:     inc_d = entry.arg[1];
			OP_HOME, OP_CLEAR: addr_d = '0;
			OP_WRITE, OP_READ: addr_d = inc_q ? addr_q + 7'd1 : addr_q - 7'd1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx] <= entry.arg;
		end
		if (mem_re) begin
			mem_s2 <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			disp_q  <= 1'b1;
			cur_q   <= 1'b0;
			blink_q <= 1'b0;
			inc_q   <= 1'b1;
			eight_q <= 1'b1;
			two_q   <= 1'b0;
			valid_q <= '0;
			fill_q  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= avail;
			if (avail) begin
				addr_q  <= addr_d;
				disp_q  <= disp_d;
				cur_q   <= cur_d;
				blink_q <= blink_d;
				inc_q   <= inc_d;
				eight_q <= eight_d;
				two_q   <= two_d;
			end
			if (clr) begin
				valid_q <= '0;
				fill_q  <= 1'b1;
			end else if (mem_we) begin
				valid_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (avail) begin
			rd_s2    <= (entry.op == OP_READ);
			hit_s2   <= in_range && valid_q[idx];
			blank_s2 <= in_range && fill_q;
			data_s2  <= (entry.op == OP_STATUS) ? {1'b0, addr_q} : 8'h00;
			flags_s2 <= '{rd_byte: 8'h00, address_now: addr_d, show_on: disp_d,
				cursor_on: cur_d, blink_on: blink_d, step_up: inc_d,
				wide_bus: eight_d, two_rows: two_d};
		end
	end

	always_comb begin
		rsp = flags_s2;
		if (!rd_s2) begin
			rsp.rd_byte = data_s2;
		end else if (hit_s2) begin
			rsp.rd_byte = mem_s2;
		end else if (blank_s2) begin
			rsp.rd_byte = BLANK_CHAR;
		end else begin
			rsp.rd_byte = 8'h00;
		end
	end

	assign done = done_s2;

endmodule

[sv/char_lcd_controller_bus_interface_core.sv]
// An accepted access is written into the queue; the back end pops it and
// registers the result, which is valid while done is high.
// Throughput: one bus access per cycle; the back end retires one item per
// cycle from the two-entry queue, so busy stays low in steady use.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset (arst_n low, async): queue empty, store reads as zeros, address 0,
// display on, cursor/blink off, increment, 8-bit, one line.
module char_lcd_controller_bus_interface_core import lcdc_pkg::*; #(
	parameter int TEXT_CELLS = TEXT_CELLS_DEF,
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  lcdc_req_t req,
	output logic      busy,
	output logic      done,
	output lcdc_rsp_t rsp
);

	logic        push;
	logic        full;
	logic        empty;
	logic        pop;
	lcdc_entry_t wr_entry;
	lcdc_entry_t rd_entry;

	lcdc_front u_front (
		.start (start),
		.req   (req),
		.full  (full),
		.busy  (busy),
		.push  (push),
		.entry (wr_entry)
	);

	lcdc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.rd_entry (rd_entry)
	);

	lcdc_back #(
		.TEXT_CELLS (TEXT_CELLS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (!empty),
		.entry  (rd_entry),
		.pop    (pop),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

[sv/lcdc_checker.sv]
module lcdc_checker import lcdc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input lcdc_req_t req,
	input logic      busy,
	input logic      done,
	input lcdc_rsp_t rsp
);

	logic acc;
	assign acc = start && !busy;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##2 done)
		else $error("accepted item gave no result");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, 2))
		else $error("result without accepted item");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(acc && req.cmd == ACC_STATUS, 2)
		|-> rsp.rd_byte == {1'b0, rsp.address_now})
		else $error("status read mismatch");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(acc && (req.cmd == ACC_INSTR || req.cmd == ACC_WRITE), 2)
		|-> rsp.rd_byte == 8'h00)
		else $error("write returned data");

	a_status_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && $past(acc && req.cmd == ACC_STATUS, 2)
		|-> rsp.address_now == $past(rsp.address_now))
		else $error("status read moved address");

endmodule

bind char_lcd_controller_bus_interface_core lcdc_checker u_lcdc_checker (.*);

[tb/lcdc_access_checker.sv]
`timescale 1ns / 1ps
module lcdc_access_checker import lcdc_pkg::*; #(
	parameter int TEXT_CELLS = TEXT_CELLS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  lcdc_req_t req,
	input  logic      done,
	input  lcdc_rsp_t rsp,
	output int        errors,
	output int        pending
);

	logic [7:0] cells [TEXT_CELLS];
	logic [6:0] addr_ctr;
	logic       disp_en;
	logic       curs_en;
	logic       blink_en;
	logic       inc_mode;
	logic       eight_bit;
	logic       two_line;
	lcdc_rsp_t  rsp_due[$];

	function automatic logic [6:0] stepped(input logic [6:0] a, input logic up);
		return up ? a + 7'd1 : a - 7'd1;
	endfunction

	// priority decode on the highest set bit of the instruction byte
	function automatic void run_instr(input logic [7:0] b);
		if (b[7]) begin
			addr_ctr = b[6:0];
		end else if (b[6]) begin
		end else if (b[5]) begin
			eight_bit = b[4];
			two_line  = b[3];
		end else if (b[4]) begin
			if (!b[3])
				addr_ctr = stepped(addr_ctr, b[2]);
		end else if (b[3]) begin
			disp_en  = b[2];
			curs_en  = b[1];
			blink_en = b[0];
		end else if (b[2]) begin
			inc_mode = b[1];
		end else if (b[1]) begin
			addr_ctr = '0;
		end else if (b[0]) begin
			foreach (cells[i])
				cells[i] = BLANK_CHAR;
			addr_ctr = '0;
		end
	endfunction

	function automatic lcdc_rsp_t apply_access(input lcdc_req_t r);
		lcdc_rsp_t o;
		o = '0;
		case (r.cmd)
			ACC_INSTR: begin
				run_instr(r.data_in);
			end
			ACC_STATUS: begin
				o.rd_byte = {1'b0, addr_ctr};
			end
			ACC_WRITE: begin
				if (addr_ctr < TEXT_CELLS)
					cells[addr_ctr] = r.data_in;
				addr_ctr = stepped(addr_ctr, inc_mode);
			end
			default: begin
				if (addr_ctr < TEXT_CELLS)
					o.rd_byte = cells[addr_ctr];
				addr_ctr = stepped(addr_ctr, inc_mode);
			end
		endcase
		o.address_now = addr_ctr;
		o.show_on     = disp_en;
		o.cursor_on   = curs_en;
		o.blink_on    = blink_en;
		o.step_up     = inc_mode;
		o.wide_bus    = eight_bit;
		o.two_rows    = two_line;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lcdc_rsp_t exp_rsp;
		if (!arst_n) begin
			foreach (cells[i])
				cells[i] = '0;
			addr_ctr  = '0;
			disp_en   = 1'b1;
			curs_en   = 1'b0;
			blink_en  = 1'b0;
			inc_mode  = 1'b1;
			eight_bit = 1'b1;
			two_line  = 1'b0;
			rsp_due.delete();
		end else begin
			if (done) begin
				if (rsp_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, actual %h", $time, rsp);
				end else begin
					exp_rsp = rsp_due.pop_front();
					check_field("rd_byte", exp_rsp.rd_byte, rsp.rd_byte);
					check_field("address_now", 8'(exp_rsp.address_now),
						8'(rsp.address_now));
					check_field("show_on", 8'(exp_rsp.show_on), 8'(rsp.show_on));
					check_field("cursor_on", 8'(exp_rsp.cursor_on), 8'(rsp.cursor_on));
					check_field("blink_on", 8'(exp_rsp.blink_on), 8'(rsp.blink_on));
					check_field("step_up", 8'(exp_rsp.step_up), 8'(rsp.step_up));
					check_field("wide_bus", 8'(exp_rsp.wide_bus), 8'(rsp.wide_bus));
					check_field("two_rows", 8'(exp_rsp.two_rows), 8'(rsp.two_rows));
				end
			end
			if (start && !busy)
				rsp_due.push_back(apply_access(req));
		end
		pending = rsp_due.size();
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench import lcdc_pkg::*;;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int N_RANDOM     = 1050;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [7:0] INS_CLEAR = 8'h01;
	localparam logic [7:0] INS_HOME  = 8'h02;
	localparam logic [7:0] INS_ENTRY = 8'h04;
	localparam logic [7:0] INS_DISP  = 8'h08;
	localparam logic [7:0] INS_SHIFT = 8'h10;
	localparam logic [7:0] INS_FUNC  = 8'h20;
	localparam logic [7:0] INS_CGRAM = 8'h40;
	localparam logic [7:0] INS_DDRAM = 8'h80;
	localparam logic [7:0] TOP_CELL  = 8'(TEXT_CELLS_DEF - 1);

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	lcdc_req_t req    = '0;
	logic      busy;
	logic      done;
	lcdc_rsp_t rsp;
	int        errors;
	int        pending;
	int        cycles = 0;
	lcdc_req_t plan[$];

	lcdc_req_t directed[$] = '{
		{ACC_STATUS, 8'h00},
		{ACC_READ, 8'h00},
		{ACC_INSTR, INS_DDRAM},
		{ACC_WRITE, 8'hFF},
		{ACC_WRITE, 8'h00},
		{ACC_INSTR, INS_DDRAM | TOP_CELL},
		{ACC_WRITE, 8'hA5},
		{ACC_READ, 8'h00},
		{ACC_INSTR, 8'hFF},
		{ACC_WRITE, 8'h5A},
		{ACC_INSTR, INS_ENTRY},
		{ACC_READ, 8'h00},
		{ACC_INSTR, INS_SHIFT | 8'h04},
		{ACC_INSTR, INS_SHIFT},
		{ACC_INSTR, INS_SHIFT | 8'h0C},
		{ACC_INSTR, INS_ENTRY | 8'h03},
		{ACC_INSTR, INS_DISP | 8'h07},
		{ACC_INSTR, INS_DISP},
		{ACC_INSTR, INS_FUNC | 8'h1F},
		{ACC_INSTR, INS_FUNC},
		{ACC_INSTR, INS_CGRAM | 8'h3F},
		{ACC_INSTR, 8'h00},
		{ACC_INSTR, INS_HOME | 8'h01},
		{ACC_INSTR, INS_CLEAR},
		{ACC_READ, 8'h00},
		{ACC_STATUS, 8'hFF}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	char_lcd_controller_bus_interface_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	lcdc_access_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.errors  (errors),
		.pending (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic send_access(input lcdc_req_t r);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [7:0] random_instr();
		logic [7:0] b;
		b = 8'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				if ($urandom_range(0, 4) != 0)
					return INS_DDRAM | 8'($urandom_range(0, TEXT_CELLS_DEF + 1));
				return INS_DDRAM | b;
			end
			1: return INS_CGRAM | (b & 8'h3F);
			2: return INS_FUNC | (b & 8'h1F);
			3: return INS_SHIFT | (b & 8'h0F);
			4: return INS_DISP | (b & 8'h07);
			5: return INS_ENTRY | (b & 8'h03);
			6: return INS_HOME | (b & 8'h01);
			7: return INS_CLEAR;
			8: return 8'h00;
			default: return b;
		endcase
	endfunction

	// either a write-then-readback run over the store or one loose access
	task automatic plan_more;
		int         k;
		int         pick;
		logic [7:0] base;
		if ($urandom_range(0, 99) < 40) begin
			base = INS_DDRAM | 8'($urandom_range(0, TEXT_CELLS_DEF - 1));
			k = $urandom_range(1, 8);
			if ($urandom_range(0, 4) == 0)
				plan.push_back({ACC_INSTR, INS_ENTRY | 8'($urandom_range(0, 3))});
			plan.push_back({ACC_INSTR, base});
			repeat (k) plan.push_back({ACC_WRITE, 8'($urandom)});
			plan.push_back({ACC_INSTR, base});
			repeat (k) plan.push_back({ACC_READ, 8'($urandom)});
			if ($urandom_range(0, 1) == 0)
				plan.push_back({ACC_STATUS, 8'($urandom)});
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 35)
				plan.push_back({ACC_WRITE, 8'($urandom)});
			else if (pick < 60)
				plan.push_back({ACC_READ, 8'($urandom)});
			else if (pick < 68)
				plan.push_back({ACC_STATUS, 8'($urandom)});
			else
				plan.push_back({ACC_INSTR, random_instr()});
		end
	endtask

	initial begin
		int sent;
		int burst;
		int gap;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_access(directed[i]);
		drain_results();

		sent = 0;
		while (sent < N_RANDOM) begin
			if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(30, 80);
				gap   = 0;
			end else begin
				burst = $urandom_range(1, 12);
				gap   = $urandom_range(0, 5);
			end
			repeat (burst) begin
				if (plan.size() == 0)
					plan_more();
				send_access(plan.pop_front());
				sent++;
			end
			if ($urandom_range(0, 29) == 0)
				drain_results();
			else
				idle_for(gap);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
